// File: rtl/byte_ring_fifo_with_runs_top_assert.svh
// Assertion macros for the byte ring FIFO checker.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef BYTE_RING_FIFO_WITH_RUNS_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_RUNS_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/brf_pkg.sv
// Shared constants, command codes and the result descriptor type
// for the byte ring FIFO. No dependencies.
`default_nettype none

package brf_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = 8;
  localparam int CNT_W  = 9;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CMD_W  = 3;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [LEN_W-1:0] MAX_RUN  = 7'd64;
  localparam logic [CNT_W-1:0] CAP_MAX  = 9'd256;

  localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_RUN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_RUN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_RUN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISCARD  = 3'd5;

  typedef struct packed {
    logic             ok;
    logic             last;
    logic [CNT_W-1:0] fill_cnt;
    logic [CNT_W-1:0] free_cnt;
    logic             empty;
    logic             full;
    logic             use_mem;
  } brf_rslt_t;

endpackage

`default_nettype wire

// File: rtl/brf_mem.sv
// Byte store: 256 x 8 synchronous RAM, one write and one registered read port.
// Depends on brf_pkg.
`default_nettype none

module brf_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [brf_pkg::ADDR_W-1:0] waddr,
  input  wire logic [brf_pkg::BYTE_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [brf_pkg::ADDR_W-1:0] raddr,
  output logic      [brf_pkg::BYTE_W-1:0] rdata
);
  import brf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/brf_ctrl.sv
// Command decode, ring pointers, fill count, push-run state and the
// pop/peek run sequencer. Depends on brf_pkg.
`default_nettype none

module brf_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [brf_pkg::CNT_W-1:0]  cfg_wr_data,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [brf_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [brf_pkg::BYTE_W-1:0] in_data,
  input  wire logic [brf_pkg::LEN_W-1:0]  in_len,
  input  wire logic                       slot_free,
  output logic                            rslt_valid,
  output brf_pkg::brf_rslt_t              rslt,
  output logic                            mem_we,
  output logic      [brf_pkg::ADDR_W-1:0] mem_waddr,
  output logic      [brf_pkg::BYTE_W-1:0] mem_wdata,
  output logic                            mem_re,
  output logic      [brf_pkg::ADDR_W-1:0] mem_raddr
);
  import brf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r,    state_nxt;
  logic [CNT_W-1:0]  cap_r,      cap_nxt;
  logic [ADDR_W-1:0] rd_ptr_r,   rd_ptr_nxt;
  logic [ADDR_W-1:0] wr_ptr_r,   wr_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r,      cnt_nxt;
  logic [LEN_W-1:0]  run_left_r, run_left_nxt;
  logic              run_rej_r,  run_rej_nxt;
  logic [LEN_W-1:0]  seq_left_r, seq_left_nxt;
  logic [ADDR_W-1:0] seq_ptr_r,  seq_ptr_nxt;
  logic              seq_pop_r,  seq_pop_nxt;

  logic              acc;
  logic [CNT_W-1:0]  free_now;
  logic [CNT_W-1:0]  len_ext;
  logic              len_bad;
  logic [LEN_W-1:0]  eff_left;
  logic              eff_rej;
  logic [CNT_W-1:0]  rd_sum;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p,
                                                input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] n;
    n = {1'b0, p} + 9'd1;
    return (n >= cap) ? '0 : n[ADDR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cap_sat(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v;
    if (v == '0) begin
      c = 9'd1;
    end else if (v > CAP_MAX) begin
      c = CAP_MAX;
    end
    return c;
  endfunction

  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;
  assign free_now  = cap_r - cnt_r;
  assign len_ext   = {2'b00, in_len};
  assign len_bad   = (in_len > MAX_RUN) || (cnt_r < len_ext);
  assign eff_left  = (run_left_r == '0) ? in_len : run_left_r;
  assign eff_rej   = (run_left_r == '0) ? ((in_len > MAX_RUN) || (free_now < len_ext))
                                        : run_rej_r;
  assign rd_sum    = ({1'b0, rd_ptr_r} + len_ext >= cap_r)
                   ? ({1'b0, rd_ptr_r} + len_ext - cap_r)
                   : ({1'b0, rd_ptr_r} + len_ext);

  always_comb begin
    state_nxt    = state_r;
    cap_nxt      = cap_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    cnt_nxt      = cnt_r;
    run_left_nxt = run_left_r;
    run_rej_nxt  = run_rej_r;
    seq_left_nxt = seq_left_r;
    seq_ptr_nxt  = seq_ptr_r;
    seq_pop_nxt  = seq_pop_r;
    rslt_valid   = 1'b0;
    rslt.ok      = 1'b0;
    rslt.last    = 1'b1;
    rslt.use_mem = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wr_ptr_r;
    mem_wdata    = in_data;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_r;

    // Run sequencer: one memory read and one result per byte.
    if ((state_r == ST_RUN) && slot_free) begin
      mem_re       = 1'b1;
      mem_raddr    = seq_ptr_r;
      rslt_valid   = 1'b1;
      rslt.ok      = 1'b1;
      rslt.use_mem = 1'b1;
      rslt.last    = (seq_left_r == 7'd1);
      seq_ptr_nxt  = ptr_inc(seq_ptr_r, cap_r);
      seq_left_nxt = seq_left_r - 7'd1;
      if (seq_pop_r) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r, cap_r);
        cnt_nxt    = cnt_r - 9'd1;
      end
      if (seq_left_r == 7'd1) begin
        state_nxt = ST_IDLE;
      end
    end

    if (acc) begin
      rslt_valid = 1'b1;
      // Any other command closes an open push run.
      if (in_cmd != CMD_PUSH_RUN) begin
        run_left_nxt = '0;
        run_rej_nxt  = 1'b0;
      end
      unique case (in_cmd)
        CMD_PUSH: begin
          if (cnt_r != cap_r) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = ptr_inc(wr_ptr_r, cap_r);
            cnt_nxt    = cnt_r + 9'd1;
            rslt.ok    = 1'b1;
          end
        end
        CMD_POP: begin
          if (cnt_r != '0) begin
            mem_re       = 1'b1;
            rslt.use_mem = 1'b1;
            rd_ptr_nxt   = ptr_inc(rd_ptr_r, cap_r);
            cnt_nxt      = cnt_r - 9'd1;
            rslt.ok      = 1'b1;
          end
        end
        CMD_PUSH_RUN: begin
          if ((run_left_r == '0) && (in_len == '0)) begin
            rslt.ok = 1'b1;
          end else begin
            rslt.ok = !eff_rej;
            if (!eff_rej) begin
              mem_we     = 1'b1;
              wr_ptr_nxt = ptr_inc(wr_ptr_r, cap_r);
              cnt_nxt    = cnt_r + 9'd1;
            end
            run_left_nxt = eff_left - 7'd1;
            run_rej_nxt  = (eff_left == 7'd1) ? 1'b0 : eff_rej;
          end
        end
        CMD_POP_RUN, CMD_PEEK_RUN: begin
          if (in_len == '0) begin
            rslt.ok = 1'b1;
          end else if (!len_bad) begin
            // Hand over to the sequencer; it emits every byte.
            rslt_valid   = 1'b0;
            state_nxt    = ST_RUN;
            seq_left_nxt = in_len;
            seq_ptr_nxt  = rd_ptr_r;
            seq_pop_nxt  = (in_cmd == CMD_POP_RUN);
          end
        end
        CMD_DISCARD: begin
          if (in_len == '0) begin
            rslt.ok = 1'b1;
          end else if (!len_bad) begin
            rd_ptr_nxt = rd_sum[ADDR_W-1:0];
            cnt_nxt    = cnt_r - len_ext;
            rslt.ok    = 1'b1;
          end
        end
        default: begin
          rslt.ok = 1'b0;
        end
      endcase
    end

    if (cfg_wr_en) begin
      cap_nxt      = cap_sat(cfg_wr_data);
      rd_ptr_nxt   = '0;
      wr_ptr_nxt   = '0;
      cnt_nxt      = '0;
      run_left_nxt = '0;
      run_rej_nxt  = 1'b0;
    end

    rslt.fill_cnt = cnt_nxt;
    rslt.free_cnt = cap_r - cnt_nxt;
    rslt.empty    = (cnt_nxt == '0);
    rslt.full     = (cnt_nxt == cap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cap_r      <= CAP_MAX;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      cnt_r      <= '0;
      run_left_r <= '0;
      run_rej_r  <= 1'b0;
      seq_left_r <= '0;
      seq_ptr_r  <= '0;
      seq_pop_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cap_r      <= cap_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      cnt_r      <= cnt_nxt;
      run_left_r <= run_left_nxt;
      run_rej_r  <= run_rej_nxt;
      seq_left_r <= seq_left_nxt;
      seq_ptr_r  <= seq_ptr_nxt;
      seq_pop_r  <= seq_pop_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/brf_oreg.sv
// Result path: a descriptor stage that waits for the RAM read data, then the
// output register. Depends on brf_pkg.
`default_nettype none

module brf_oreg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            rslt_valid,
  input  wire brf_pkg::brf_rslt_t              rslt,
  input  wire logic [brf_pkg::BYTE_W-1:0]      mem_rdata,
  output logic                                 slot_free,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [brf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                 out_tlast
);
  import brf_pkg::*;

  logic                   s1_v_r,  s1_v_nxt;
  brf_rslt_t              s1_r;
  logic                   out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;
  logic                   out_free;
  logic                   s1_adv;
  logic [BYTE_W-1:0]      rbyte;

  assign out_free  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && out_free;
  assign slot_free = !s1_v_r || s1_adv;
  assign rbyte     = s1_r.use_mem ? mem_rdata : '0;

  always_comb begin
    s1_v_nxt  = slot_free ? rslt_valid : 1'b1;
    out_v_nxt = s1_adv || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && rslt_valid) begin
      s1_r <= rslt;
    end
    if (s1_adv) begin
      out_data_r <= {3'b000, s1_r.full, s1_r.empty, s1_r.free_cnt, s1_r.fill_cnt,
                     s1_r.ok, rbyte};
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: rtl/byte_ring_fifo_with_runs_top.sv
// Top level of the byte ring FIFO with run commands.
// Depends on brf_pkg, brf_mem, brf_ctrl and brf_oreg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in_     | slave     | in_tvalid/in_tready  | tuser: command; tdata: data, length
//   out_    | master    | out_tvalid/out_tready| tdata: result fields; tlast: last
//   cfg_    | write     | cfg_wr_en            | cfg_wr_data: capacity_in_use
//
// Single push, pop, push-run byte, discard and failing commands are accepted
// back to back while the descriptor stage has room; a result passes through the
// descriptor stage and the output register. A successful pop or peek run of N
// bytes holds the input while the single RAM read port is read once per byte.
// Reset is synchronous and clears pointers, counts and run state; the RAM is
// not cleared, since only bytes written since reset are ever read.
// With out_tready low the output register and the descriptor stage hold, and
// the input stalls once the descriptor stage is full.
`default_nettype none

module byte_ring_fifo_with_runs_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [brf_pkg::CNT_W-1:0]           cfg_wr_data,  // capacity_in_use
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] data, [14:8] length, [15] zero
  input  wire logic [brf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] command
  input  wire logic [brf_pkg::CMD_W-1:0]           in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] read_byte, [8] ok, [17:9] fill_count, [26:18] free_count,
  // [27] is_empty, [28] is_full, [31:29] zero
  output logic      [brf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                     out_tlast
);
  import brf_pkg::*;

  logic              slot_free;
  logic              rslt_valid;
  brf_rslt_t         rslt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Decode commands and advance the ring state.
  brf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_cmd      (in_tuser),
    .in_data     (in_tdata[BYTE_W-1:0]),
    .in_len      (in_tdata[BYTE_W+LEN_W-1:BYTE_W]),
    .slot_free   (slot_free),
    .rslt_valid  (rslt_valid),
    .rslt        (rslt),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr)
  );

  // Hold the stored bytes.
  brf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Merge read data into the result and drive the output transaction.
  brf_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .rslt_valid (rslt_valid),
    .rslt       (rslt),
    .mem_rdata  (mem_rdata),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/brf_checker.sv
// Port-level checks for the byte ring FIFO top, attached by bind.
// Depends on byte_ring_fifo_with_runs_top_assert.svh.
`default_nettype none
`include "byte_ring_fifo_with_runs_top_assert.svh"

module brf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  `BRF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `BRF_ASSERT_IMP(a_flags_excl, out_tvalid, !(out_tdata[27] && out_tdata[28]), "empty and full together")
  `BRF_ASSERT_IMP(a_count_sum, out_tvalid, ({1'b0, out_tdata[17:9]} + {1'b0, out_tdata[26:18]}) <= 10'd256, "fill plus free exceeds depth")
  `BRF_ASSERT_IMP(a_empty_cnt, out_tvalid, out_tdata[27] == (out_tdata[17:9] == 9'd0), "empty flag disagrees with fill count")
  `BRF_ASSERT_IMP(a_fail_last, out_tvalid && !out_tdata[8], out_tlast && (out_tdata[7:0] == 8'd0), "failed result not single")

endmodule

bind byte_ring_fifo_with_runs_top brf_checker u_brf_checker (.*);

`default_nettype wire
